// File: hdl/md5_pkg.sv
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadMarker = 8'h80;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW = 1;

  typedef enum logic {
    FUNC_DATA   = 1'b0,
    FUNC_FINISH = 1'b1
  } func_e;

  typedef struct packed {
    func_e      func;
    logic [7:0] data_byte;
  } item_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;   6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;   6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;   6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;   6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;   6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/md5_stream_if.sv
interface md5_in_if;
  import md5_pkg::*;
  logic       valid;
  logic       ready;
  func_e      func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink (input valid, func, data_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last;
  modport source (output valid, digest_word, word_index, last, input ready);
  modport sink (input valid, digest_word, word_index, last, output ready);
endinterface

// File: hdl/md5_front.sv
// Input stage and short queue: items wait here while the core is busy.
module md5_front
  import md5_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  md5_in_if.sink in_if,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  item_pop_i
);

  item_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QueuePtrW:0]    cnt_q, cnt_d;
  logic                  push;

  assign in_if.ready  = (cnt_q != (QueuePtrW+1)'(QueueDepth));
  assign push         = in_if.valid && in_if.ready;
  assign item_valid_o = (cnt_q != '0);
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = push ? wr_q + 1'b1 : wr_q;
    rd_d  = item_pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(item_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{func: in_if.func, data_byte: in_if.data_byte};
    end
  end

endmodule

// File: hdl/md5_core.sv
// Block buffer, padding sequencer and the one-round-per-cycle compression.
module md5_core
  import md5_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  md5_out_if.source out_if
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PAD  = 6'b000010,
    ST_LEN  = 6'b000100,
    ST_RND  = 6'b001000,
    ST_ADD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  buf_q [16];
  logic [31:0]  h_q [4];
  logic [31:0]  a_q, b_q, c_q, d_q;
  logic [63:0]  bits_q;
  logic [5:0]   pos_q;       // next byte position while padding
  logic [5:0]   rnd_q;
  logic         fin_q;       // compression belongs to a finish
  logic         lenblk_q;    // compression carries the length
  logic [1:0]   oidx_q;

  logic [5:0]   wpos;
  logic [31:0]  f, t, tr, m;
  logic [3:0]   g;
  logic [1:0]   stg;
  logic [4:0]   sh;

  assign wpos = bits_q[8:3];
  assign stg  = rnd_q[5:4];

  always_comb begin
    case (stg)
      2'd0: begin f = d_q ^ (b_q & (c_q ^ d_q)); g = rnd_q[3:0]; end
      2'd1: begin f = c_q ^ (d_q & (b_q ^ c_q)); g = 4'(rnd_q * 3'd5 + 1'b1); end
      2'd2: begin f = b_q ^ c_q ^ d_q; g = 4'(rnd_q * 2'd3 + 3'd5); end
      default: begin f = c_q ^ (b_q | ~d_q); g = 4'(rnd_q * 3'd7); end
    endcase
    m  = buf_q[g];
    t  = a_q + f + round_const(rnd_q) + m;
    sh = rot_amount({stg, rnd_q[1:0]});
    tr = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  assign item_pop_o         = (state_q == ST_IDLE) && item_valid_i;
  assign out_if.valid       = (state_q == ST_OUT);
  assign out_if.digest_word = h_q[oidx_q];
  assign out_if.word_index  = oidx_q;
  assign out_if.last        = (oidx_q == 2'd3);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (item_valid_i) begin
        if (item_i.func == FUNC_FINISH) state_d = (wpos > 6'd55) ? ST_PAD : ST_LEN;
        else if (wpos == 6'd63) state_d = ST_RND;
      end
      ST_PAD:  if (pos_q == 6'd63) state_d = ST_RND;
      ST_LEN:  state_d = ST_RND;
      ST_RND:  if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD:  state_d = (lenblk_q) ? ST_OUT : (fin_q ? ST_LEN : ST_IDLE);
      ST_OUT:  if (out_if.ready && oidx_q == 2'd3) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      h_q      <= '{InitA, InitB, InitC, InitD};
      bits_q   <= '0;
      rnd_q    <= '0;
      fin_q    <= 1'b0;
      lenblk_q <= 1'b0;
      oidx_q   <= '0;
      pos_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: if (item_valid_i) begin
          rnd_q <= '0;
          if (item_i.func == FUNC_FINISH) begin
            fin_q    <= 1'b1;
            lenblk_q <= 1'b0;
            pos_q    <= wpos + 1'b1;
          end else begin
            bits_q   <= bits_q + 64'd8;
            fin_q    <= 1'b0;
            lenblk_q <= 1'b0;
          end
        end
        ST_PAD:  pos_q <= pos_q + 1'b1;
        ST_LEN:  lenblk_q <= 1'b1;
        ST_RND:  rnd_q <= rnd_q + 1'b1;
        ST_ADD: begin
          h_q[0] <= h_q[0] + a_q;
          h_q[1] <= h_q[1] + b_q;
          h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q;
        end
        ST_OUT: if (out_if.ready) begin
          oidx_q <= oidx_q + 1'b1;
          if (oidx_q == 2'd3) begin
            h_q    <= '{InitA, InitB, InitC, InitD};
            bits_q <= '0;
            fin_q  <= 1'b0;
            lenblk_q <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload: block buffer and working variables.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (item_valid_i) begin
        if (item_i.func == FUNC_FINISH) begin
          buf_q[wpos[5:2]][8*wpos[1:0] +: 8] <= PadMarker;
          // Zero the rest of the block; the length words are set later.
          for (int i = 0; i < 64; i++) begin
            if (6'(i) > wpos) buf_q[i/4][8*(i%4) +: 8] <= 8'h00;
          end
        end else begin
          buf_q[wpos[5:2]][8*wpos[1:0] +: 8] <= item_i.data_byte;
        end
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
      end
      ST_LEN: begin
        // A spilled block needs the data words cleared for the second pass.
        if (fin_q && rnd_q == 6'd0 && pos_q == 6'd0) begin
          for (int i = 0; i < 14; i++) buf_q[i] <= '0;
        end
        buf_q[14] <= bits_q[31:0];
        buf_q[15] <= bits_q[63:32];
        a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
      end
      ST_RND: begin
        a_q <= d_q;
        d_q <= c_q;
        c_q <= b_q;
        b_q <= b_q + tr;
      end
      ST_ADD: if (fin_q && !lenblk_q) begin
        for (int i = 0; i < 14; i++) buf_q[i] <= '0;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/md5_stream_hash.sv
// Channel  | Dir | Payload
// in_if    | in  | func, data_byte
// out_if   | out | digest_word, word_index, last
//
// A data byte is written into the block buffer; the 64th byte of a block starts
// compression (one MD5 round per cycle through the single round unit).
// A finish pads and compresses the block, or two blocks when the padding spills
// into a second block (the padding state idles up to byte position 63), then
// gives four output transactions.
// Reset is asynchronous, active low, and loads the MD5 initial chaining words.
// A two-entry queue takes bytes until full while the core compresses; the core
// holds each digest word until the sink takes it.
module md5_stream_hash
  import md5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  md5_in_if.sink      in_if,
  md5_out_if.source   out_if
);

  logic  item_valid, item_pop;
  item_t item;

  md5_front u_front (
    .clk_i, .rst_ni, .in_if,
    .item_valid_o(item_valid), .item_o(item), .item_pop_i(item_pop)
  );

  md5_core u_core (
    .clk_i, .rst_ni,
    .item_valid_i(item_valid), .item_i(item), .item_pop_o(item_pop), .out_if
  );

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid) else $error("pop from empty queue");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && out_if.last |-> out_if.word_index == 2'd3)
    else $error("last flag on wrong word");
  a_no_pop_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !item_pop) else $error("item taken while digest pending");
`endif

endmodule

// File: tb/sv/md5_stream_hash_checker.sv
`timescale 1ns / 100ps

module md5_stream_hash_checker
  import md5_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  md5_in_if  in_mon,
  md5_out_if out_mon,
  output int unsigned fail_count_o,
  output int unsigned digest_pending_o
);

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last;
  } digest_t;

  logic [31:0] chain_q [4];
  logic [31:0] block_q [16];
  logic [63:0] msg_bits_q;
  digest_t     digest_fifo [$];
  int unsigned fail_count;
  int unsigned pending_count;

  function automatic logic [31:0] rol(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] add_const(input int i);
    logic [31:0] t;
    t = 32'(longint'($floor($pow(2.0, 32.0) * (($sin(i + 1.0) < 0.0) ?
        -$sin(i + 1.0) : $sin(i + 1.0)))));
    return t;
  endfunction

  task automatic fold_block();
    logic [31:0] a, b, c, d, f, t;
    int g, i;
    int shifts [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = chain_q[0];
    b = chain_q[1];
    c = chain_q[2];
    d = chain_q[3];
    for (i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = rol(a + f + add_const(i) + block_q[g], shifts[(i / 16) * 4 + i % 4]);
      a = d;
      d = c;
      c = b;
      b = b + t;
    end
    chain_q[0] += a;
    chain_q[1] += b;
    chain_q[2] += c;
    chain_q[3] += d;
  endtask

  task automatic store_byte(input int pos, input logic [7:0] v);
    block_q[pos / 4][(pos % 4) * 8 +: 8] = v;
  endtask

  task automatic restart_message();
    chain_q[0] = InitA;
    chain_q[1] = InitB;
    chain_q[2] = InitC;
    chain_q[3] = InitD;
    msg_bits_q = '0;
  endtask

  task automatic absorb_item(input func_e fn, input logic [7:0] v);
    int pos;
    digest_t w;
    pos = int'(msg_bits_q[8:3]);
    if (fn == FUNC_DATA) begin
      store_byte(pos, v);
      msg_bits_q += 64'd8;
      if (pos == 63) fold_block();
    end else begin
      store_byte(pos, PadMarker);
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          store_byte(pos, 8'h00);
          pos++;
        end
        fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        store_byte(pos, 8'h00);
        pos++;
      end
      block_q[14] = msg_bits_q[31:0];
      block_q[15] = msg_bits_q[63:32];
      fold_block();
      for (int k = 0; k < 4; k++) begin
        w.digest_word = chain_q[k];
        w.word_index = 2'(k);
        w.last = (k == 3);
        digest_fifo.push_back(w);
      end
      restart_message();
    end
  endtask

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    for (int i = 0; i < 16; i++) block_q[i] = '0;
    restart_message();
  end

  always @(posedge clk_i) begin
    digest_t w;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        if (digest_fifo.size() == 0) begin
          report("digest transaction with nothing expected");
        end else begin
          w = digest_fifo.pop_front();
          if (out_mon.digest_word !== w.digest_word)
            report($sformatf("word %0d got %h want %h", w.word_index,
                             out_mon.digest_word, w.digest_word));
          if (out_mon.word_index !== w.word_index)
            report($sformatf("index got %0d want %0d", out_mon.word_index, w.word_index));
          if (out_mon.last !== w.last)
            report($sformatf("last got %b want %b", out_mon.last, w.last));
        end
      end
      if (in_mon.valid && in_mon.ready) absorb_item(in_mon.func, in_mon.data_byte);
      pending_count = digest_fifo.size();
    end
  end

  assign fail_count_o = fail_count;
  assign digest_pending_o = pending_count;

endmodule

// File: tb/sv/md5_stream_hash_tb.sv
`timescale 1ns / 100ps

module md5_stream_hash_tb;
  import md5_pkg::*;

  logic clk_i;
  logic rst_ni;
  int unsigned fail_count;
  int unsigned digest_pending;
  int unsigned hold_cycles;
  int unsigned byte_total;
  int len_list [4] = '{55, 56, 63, 64};

  md5_in_if  in_if ();
  md5_out_if out_if ();

  md5_stream_hash DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_if),
    .out_if(out_if)
  );

  md5_stream_hash_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .fail_count_o    (fail_count),
    .digest_pending_o(digest_pending)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic send_item(input func_e fn, input logic [7:0] v, input bit gaps);
    int unsigned gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.func      <= fn;
    in_if.data_byte <= v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    byte_total++;
  endtask

  task automatic send_message(input int len, input bit gaps);
    for (int i = 0; i < len; i++) send_item(FUNC_DATA, 8'($urandom), gaps);
    send_item(FUNC_FINISH, 8'($urandom), gaps);
  endtask

  task automatic drain_digests();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (digest_pending != 0) @(posedge clk_i);
  endtask

  // Sink side: random stalls, or a long hold-off while hold_cycles is nonzero.
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int len;
    hold_cycles = 0;
    byte_total = 0;
    rst_ni = 1'b0;
    in_if.valid     <= 1'b0;
    in_if.func      <= FUNC_DATA;
    in_if.data_byte <= 8'h00;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, then byte extremes, then lengths around the padding spill.
    send_item(FUNC_FINISH, 8'hff, 1'b0);
    send_item(FUNC_DATA, 8'h00, 1'b0);
    send_item(FUNC_DATA, 8'hff, 1'b0);
    send_item(FUNC_DATA, 8'h80, 1'b0);
    send_item(FUNC_FINISH, 8'h00, 1'b0);
    drain_digests();
    foreach (len_list[i]) begin
      send_message(len_list[i], 1'b1);
    end
    drain_digests();

    // Long sink hold-off while further messages are offered.
    hold_cycles = 600;
    send_message(8, 1'b0);
    send_message(3, 1'b0);
    drain_digests();

    while (byte_total < 275) begin
      len = $urandom_range(0, 12);
      send_message(len, $urandom_range(0, 2) != 0);
    end
    drain_digests();
    repeat (200) @(posedge clk_i);

    if (fail_count == 0 && digest_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: md5_stream_hash.f
hdl/md5_pkg.sv
hdl/md5_stream_if.sv
hdl/md5_front.sv
hdl/md5_core.sv
hdl/md5_stream_hash.sv
tb/sv/md5_stream_hash_checker.sv
tb/sv/md5_stream_hash_tb.sv
